FILE: sv/facs_pkg.sv
// Shared types, codes and command tables for the focus actuator command sequencer.
// Used by facs_front, facs_queue, facs_back and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package facs_pkg;

	localparam logic [1:0] KIND_MOVE    = 2'd0;
	localparam logic [1:0] KIND_OPEN    = 2'd1;
	localparam logic [1:0] KIND_RELEASE = 2'd2;
	localparam logic [1:0] KIND_TICK    = 2'd3;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_RANGE     = 2'd1;
	localparam logic [1:0] STATUS_AT_TARGET = 2'd2;

	localparam logic CFG_INFINITY = 1'b0;
	localparam logic CFG_MACRO    = 1'b1;

	localparam logic [15:0] RAMP_COARSE_ABOVE = 16'd300;
	localparam logic [15:0] RAMP_COARSE_STEP  = 16'd30;
	localparam logic [15:0] RAMP_FINE_ABOVE   = 16'd5;
	localparam logic [15:0] RAMP_FINE_STEP    = 16'd5;

	localparam logic [3:0] SLEW_INIT    = 4'hF;
	localparam logic [3:0] SLEW_RELEASE = 4'hD;
	localparam logic [3:0] SLEW_DRIVE   = 4'h5;

	localparam logic [15:0] CMD_POWER_DOWN = 16'h8000;

	typedef enum logic [3:0] {
		MODE_DISABLED  = 4'b0001,
		MODE_INIT      = 4'b0010,
		MODE_DRIVING   = 4'b0100,
		MODE_RELEASING = 4'b1000
	} mode_t;

	typedef enum logic [2:0] {
		OPEN_CLOSED = 3'b001,
		OPEN_FRESH  = 3'b010,
		OPEN_IN_USE = 3'b100
	} open_t;

	typedef enum logic [1:0] {
		SEQ_NONE  = 2'd0,
		SEQ_INIT  = 2'd1,
		SEQ_DRIVE = 2'd2
	} seq_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [9:0]  target_position;
		logic [15:0] readback_position;
	} item_t;

	typedef struct packed {
		logic        has_command;
		logic [7:0]  command_high;
		logic [7:0]  command_low;
		logic [1:0]  result_status;
		logic [15:0] current_position;
		logic        is_open;
		logic        ramp_active;
		logic        last_of_run;
	} result_t;

	typedef struct packed {
		seq_t        seq;
		logic        has_tail;
		logic [15:0] tail_word;
		logic [1:0]  status;
		logic [15:0] position;
		logic        is_open;
		logic        ramp_active;
	} job_t;

	function automatic logic [2:0] seq_length(input seq_t seq);
		case (seq)
			SEQ_INIT:  return 3'd5;
			SEQ_DRIVE: return 3'd4;
			default:   return 3'd0;
		endcase
	endfunction

	function automatic logic [15:0] seq_word(input seq_t seq, input logic [2:0] idx);
		logic [15:0] word;
		word = 16'h0000;
		if (seq == SEQ_INIT) begin
			case (idx)
				3'd0:    word = 16'h0000;
				3'd1:    word = 16'hECA3;
				3'd2:    word = 16'hA105;
				3'd3:    word = 16'hF280;
				3'd4:    word = 16'hDC51;
				default: word = 16'h0000;
			endcase
		end else if (seq == SEQ_DRIVE) begin
			case (idx)
				3'd0:    word = 16'hECA3;
				3'd1:    word = 16'hA105;
				3'd2:    word = 16'hF200;
				3'd3:    word = 16'hDC51;
				default: word = 16'h0000;
			endcase
		end
		return word;
	endfunction

endpackage

`default_nettype wire

FILE: sv/focus_actuator_command_sequencer.sv
// Top level of the focus actuator command sequencer: front part, job queue and
// back part. Depends on facs_pkg, facs_front, facs_queue and facs_back.
//
// Requests (move, device opened, release, ramp tick) enter on item/item_valid and
// are taken at any edge where item_stall is low. Each request yields one to six
// results on result/result_valid, one result per cycle unless stalled, with the
// final one flagged by last_of_run. A request's first result passes through the
// queue and the registered output stage; the request holds the back part until
// all its results are out. The front takes a new request every cycle while the
// queue of QUEUE_DEPTH jobs has room. The limits are written through cfg_we,
// cfg_index and cfg_wdata; the user must write them only while idle, which the
// block does not enforce. Reset clears the actuator state, sets the limits to 0
// and 1023 and empties the queue and output stage. With result_stall held high,
// the result stays unchanged, the queue fills, and item_stall rises once it is full.
`timescale 1ns / 1ps
`default_nettype none

module focus_actuator_command_sequencer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [9:0]       cfg_wdata,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire facs_pkg::item_t  item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output facs_pkg::result_t     result
);

	logic           queue_full;
	logic           push;
	facs_pkg::job_t push_job;
	logic           pop;
	logic           nonempty;
	facs_pkg::job_t head;

	facs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job)
	);

	facs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (queue_full),
		.pop      (pop),
		.nonempty (nonempty),
		.head     (head)
	);

	facs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.nonempty     (nonempty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

FILE: sv/facs_front.sv
// Front part: takes requests, holds limits and actuator state, and classifies each
// request into a job for the back part. Depends on facs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module facs_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic          cfg_index,
	input  wire logic [9:0]    cfg_wdata,
	input  wire logic          item_valid,
	output logic               item_stall,
	input  wire facs_pkg::item_t item,
	input  wire logic          queue_full,
	output logic               push,
	output facs_pkg::job_t     push_job
);

	logic [9:0]       infinity_q;
	logic [9:0]       macro_q;
	logic [15:0]      lens_q;
	facs_pkg::mode_t  mode_q;
	facs_pkg::mode_t  prog_q;
	facs_pkg::open_t  open_q;
	logic             ramp_q;

	logic [15:0]      lens_n;
	facs_pkg::mode_t  mode_n;
	facs_pkg::mode_t  prog_n;
	facs_pkg::open_t  open_n;
	logic             ramp_n;

	logic [15:0]      ramp_next;
	logic [15:0]      mv_target;
	logic             out_of_range;

	assign item_stall = queue_full;
	assign push       = item_valid && !queue_full;

	assign ramp_next = lens_q - ((lens_q > facs_pkg::RAMP_COARSE_ABOVE) ?
		facs_pkg::RAMP_COARSE_STEP : facs_pkg::RAMP_FINE_STEP);
	assign mv_target = (item.kind == facs_pkg::KIND_MOVE) ?
		{6'd0, item.target_position} : ramp_next;
	assign out_of_range = (mv_target > {6'd0, macro_q}) || (mv_target < {6'd0, infinity_q});

	always_comb begin
		logic             do_move;
		logic             do_power_down;
		logic             pos_write;
		facs_pkg::mode_t  mode1;
		logic [15:0]      lens1;
		facs_pkg::open_t  open1;
		logic [3:0]       slew;

		lens_n = lens_q;
		mode_n = mode_q;
		prog_n = prog_q;
		open_n = open_q;
		ramp_n = ramp_q;
		do_move = 1'b0;
		do_power_down = 1'b0;
		pos_write = 1'b0;
		mode1 = mode_q;
		lens1 = lens_q;
		open1 = open_q;
		slew = facs_pkg::SLEW_DRIVE;
		push_job.seq = facs_pkg::SEQ_NONE;
		push_job.has_tail = 1'b0;
		push_job.tail_word = 16'h0000;
		push_job.status = facs_pkg::STATUS_OK;

		case (item.kind)
			facs_pkg::KIND_MOVE: begin
				do_move = 1'b1;
			end
			facs_pkg::KIND_OPEN: begin
				open_n = facs_pkg::OPEN_FRESH;
				ramp_n = 1'b0;
			end
			facs_pkg::KIND_RELEASE: begin
				mode_n = facs_pkg::MODE_RELEASING;
				open_n = facs_pkg::OPEN_CLOSED;
				ramp_n = 1'b1;
			end
			default: begin
				if (ramp_q) begin
					if (lens_q > facs_pkg::RAMP_FINE_ABOVE) begin
						if (out_of_range) begin
							push_job.status = facs_pkg::STATUS_RANGE;
							do_power_down = 1'b1;
						end else begin
							do_move = 1'b1;
						end
					end else begin
						do_power_down = 1'b1;
					end
				end
			end
		endcase

		if (do_power_down) begin
			mode_n = facs_pkg::MODE_DISABLED;
			ramp_n = 1'b0;
			push_job.has_tail = 1'b1;
			push_job.tail_word = facs_pkg::CMD_POWER_DOWN;
		end

		if (do_move) begin
			if (out_of_range) begin
				push_job.status = facs_pkg::STATUS_RANGE;
			end else begin
				if (open_q == facs_pkg::OPEN_FRESH) begin
					mode1 = facs_pkg::MODE_INIT;
					lens1 = item.readback_position;
					open1 = facs_pkg::OPEN_IN_USE;
				end
				mode_n = mode1;
				lens_n = lens1;
				open_n = open1;
				if (lens1 == mv_target && mode1 != facs_pkg::MODE_INIT) begin
					push_job.status = facs_pkg::STATUS_AT_TARGET;
				end else begin
					pos_write = 1'b1;
					if (mode1 == facs_pkg::MODE_INIT && prog_q != facs_pkg::MODE_INIT) begin
						push_job.seq = facs_pkg::SEQ_INIT;
						if (mv_target == 16'd0) begin
							mode_n = facs_pkg::MODE_DRIVING;
							prog_n = facs_pkg::MODE_DISABLED;
							pos_write = 1'b0;
						end else begin
							prog_n = facs_pkg::MODE_INIT;
						end
					end else if (mode1 == facs_pkg::MODE_RELEASING &&
						prog_q != facs_pkg::MODE_RELEASING) begin
						prog_n = facs_pkg::MODE_RELEASING;
					end else if (mode1 == facs_pkg::MODE_DRIVING &&
						prog_q != facs_pkg::MODE_DRIVING) begin
						push_job.seq = facs_pkg::SEQ_DRIVE;
						prog_n = facs_pkg::MODE_DRIVING;
					end
					if (mode1 == facs_pkg::MODE_INIT) begin
						slew = facs_pkg::SLEW_INIT;
					end else if (mode1 == facs_pkg::MODE_RELEASING) begin
						slew = facs_pkg::SLEW_RELEASE;
					end
					if (pos_write) begin
						push_job.has_tail = 1'b1;
						push_job.tail_word = {2'b00, mv_target[9:4], mv_target[3:0], slew};
						lens_n = {6'd0, mv_target[9:0]};
						if (mode1 == facs_pkg::MODE_INIT) begin
							mode_n = facs_pkg::MODE_DRIVING;
						end
					end
				end
			end
		end

		push_job.position = lens_n;
		push_job.is_open = (open_n != facs_pkg::OPEN_CLOSED);
		push_job.ramp_active = ramp_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			infinity_q <= 10'd0;
			macro_q <= 10'd1023;
		end else if (cfg_we) begin
			if (cfg_index == facs_pkg::CFG_INFINITY) begin
				infinity_q <= cfg_wdata;
			end else begin
				macro_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lens_q <= 16'd0;
			mode_q <= facs_pkg::MODE_DISABLED;
			prog_q <= facs_pkg::MODE_DISABLED;
			open_q <= facs_pkg::OPEN_CLOSED;
			ramp_q <= 1'b0;
		end else if (push) begin
			lens_q <= lens_n;
			mode_q <= mode_n;
			prog_q <= prog_n;
			open_q <= open_n;
			ramp_q <= ramp_n;
		end
	end

endmodule

`default_nettype wire

FILE: sv/facs_queue.sv
// Short job queue between the front and back parts of the sequencer.
// Depends on facs_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module facs_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire facs_pkg::job_t push_job,
	output logic                full,
	input  wire logic           pop,
	output logic                nonempty,
	output facs_pkg::job_t      head
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	facs_pkg::job_t entries [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = entries[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/facs_back.sv
// Back part: expands the job at the queue head into bus command results, one per
// cycle unless stalled, into a registered output stage. Depends on facs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module facs_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           nonempty,
	input  wire facs_pkg::job_t head,
	output logic                pop,
	output logic                result_valid,
	input  wire logic           result_stall,
	output facs_pkg::result_t   result
);

	logic [2:0]        idx_q;
	logic              result_valid_q;
	facs_pkg::result_t result_q;

	logic [2:0]        seq_len;
	logic [2:0]        total;
	logic              last;
	logic              advance;
	logic              emit;
	logic [15:0]       word;
	facs_pkg::result_t built;

	assign seq_len = facs_pkg::seq_length(head.seq);
	assign total   = seq_len + {2'b00, head.has_tail};
	assign last    = (total == 3'd0) || (idx_q == total - 3'd1);
	assign advance = !result_valid_q || !result_stall;
	assign emit    = advance && nonempty;
	assign pop     = emit && last;
	assign word    = (idx_q < seq_len) ? facs_pkg::seq_word(head.seq, idx_q) : head.tail_word;

	always_comb begin
		built.has_command = (total != 3'd0);
		built.command_high = (total != 3'd0) ? word[15:8] : 8'h00;
		built.command_low = (total != 3'd0) ? word[7:0] : 8'h00;
		built.result_status = head.status;
		built.current_position = head.position;
		built.is_open = head.is_open;
		built.ramp_active = head.ramp_active;
		built.last_of_run = last;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q <= built;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 3'd0;
			result_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				idx_q <= last ? 3'd0 : idx_q + 3'd1;
				result_valid_q <= 1'b1;
			end else if (advance) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

`default_nettype wire

FILE: sim/focus_actuator_command_sequencer_tb.sv
// Self-checking testbench for focus_actuator_command_sequencer: directed and random requests
// with random idling on both sides, each result checked against an internal prediction.
// Depends on facs_pkg and the focus_actuator_command_sequencer RTL.
`timescale 1ns / 1ps

module focus_actuator_command_sequencer_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SENDER = 0;
	localparam int RECEIVER = 1;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic                cfg_index;
	logic [9:0]          cfg_wdata;
	logic                item_valid;
	logic                item_stall;
	facs_pkg::item_t     request;
	logic                result_valid;
	logic                result_stall;
	facs_pkg::result_t   response;

	facs_pkg::result_t   expected_results[$];
	logic [15:0]         cmd_words[$];
	logic [15:0]         lens_q;
	facs_pkg::mode_t     motion_q;
	facs_pkg::mode_t     prog_q;
	facs_pkg::open_t     open_q;
	logic                ramp_q;
	logic [9:0]          inf_lim;
	logic [9:0]          mac_lim;
	int                  calm_left[2];
	bit                  valid_held;
	int                  sent_count;
	int                  failures;
	int                  cycle_count;

	focus_actuator_command_sequencer uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(request),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(response)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	function automatic int pick_wait(input int side);
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			calm_left[side] = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	function automatic void shut_down();
		motion_q = facs_pkg::MODE_DISABLED;
		ramp_q = 1'b0;
		cmd_words.push_back(facs_pkg::CMD_POWER_DOWN);
	endfunction

	function automatic logic [1:0] apply_move(input logic [15:0] target,
			input logic [15:0] readback);
		logic [3:0] slew;
		if (target > mac_lim || target < inf_lim)
			return facs_pkg::STATUS_RANGE;
		if (open_q == facs_pkg::OPEN_FRESH) begin
			motion_q = facs_pkg::MODE_INIT;
			lens_q = readback;
			open_q = facs_pkg::OPEN_IN_USE;
		end
		if (lens_q == target && motion_q != facs_pkg::MODE_INIT)
			return facs_pkg::STATUS_AT_TARGET;
		if (motion_q == facs_pkg::MODE_INIT && prog_q != facs_pkg::MODE_INIT) begin
			cmd_words.push_back(16'h0000);
			cmd_words.push_back(16'hECA3);
			cmd_words.push_back(16'hA105);
			cmd_words.push_back(16'hF280);
			cmd_words.push_back(16'hDC51);
			prog_q = facs_pkg::MODE_DISABLED;
			if (target == 16'd0) begin
				motion_q = facs_pkg::MODE_DRIVING;
				return facs_pkg::STATUS_OK;
			end
			prog_q = facs_pkg::MODE_INIT;
		end else if (motion_q == facs_pkg::MODE_RELEASING &&
			prog_q != facs_pkg::MODE_RELEASING) begin
			prog_q = facs_pkg::MODE_RELEASING;
		end else if (motion_q == facs_pkg::MODE_DRIVING &&
			prog_q != facs_pkg::MODE_DRIVING) begin
			cmd_words.push_back(16'hECA3);
			cmd_words.push_back(16'hA105);
			cmd_words.push_back(16'hF200);
			cmd_words.push_back(16'hDC51);
			prog_q = facs_pkg::MODE_DRIVING;
		end
		if (motion_q == facs_pkg::MODE_INIT)
			slew = facs_pkg::SLEW_INIT;
		else if (motion_q == facs_pkg::MODE_RELEASING)
			slew = facs_pkg::SLEW_RELEASE;
		else
			slew = facs_pkg::SLEW_DRIVE;
		cmd_words.push_back({target[11:4], target[3:0], slew});
		lens_q = target;
		if (motion_q == facs_pkg::MODE_INIT)
			motion_q = facs_pkg::MODE_DRIVING;
		return facs_pkg::STATUS_OK;
	endfunction

	task automatic predict_commands(input facs_pkg::item_t req);
		logic [1:0]        status;
		logic [15:0]       step;
		logic [15:0]       next;
		facs_pkg::result_t r;
		int                n;
		status = facs_pkg::STATUS_OK;
		cmd_words.delete();
		case (req.kind)
			facs_pkg::KIND_MOVE: begin
				status = apply_move({6'd0, req.target_position}, req.readback_position);
			end
			facs_pkg::KIND_OPEN: begin
				open_q = facs_pkg::OPEN_FRESH;
				ramp_q = 1'b0;
			end
			facs_pkg::KIND_RELEASE: begin
				motion_q = facs_pkg::MODE_RELEASING;
				open_q = facs_pkg::OPEN_CLOSED;
				ramp_q = 1'b1;
			end
			default: begin
				if (ramp_q) begin
					if (lens_q > facs_pkg::RAMP_FINE_ABOVE) begin
						step = (lens_q > facs_pkg::RAMP_COARSE_ABOVE) ?
							facs_pkg::RAMP_COARSE_STEP : facs_pkg::RAMP_FINE_STEP;
						next = lens_q - step;
						if (next > mac_lim || next < inf_lim) begin
							status = facs_pkg::STATUS_RANGE;
							shut_down();
						end else begin
							status = apply_move(next, req.readback_position);
						end
					end else begin
						shut_down();
					end
				end
			end
		endcase
		n = (cmd_words.size() == 0) ? 1 : cmd_words.size();
		for (int k = 0; k < n; k++) begin
			r.has_command = (cmd_words.size() != 0);
			r.command_high = r.has_command ? cmd_words[k][15:8] : 8'h00;
			r.command_low = r.has_command ? cmd_words[k][7:0] : 8'h00;
			r.result_status = status;
			r.current_position = lens_q;
			r.is_open = (open_q != facs_pkg::OPEN_CLOSED);
			r.ramp_active = ramp_q;
			r.last_of_run = (k == n - 1);
			expected_results.push_back(r);
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			failures++;
			if (failures <= 10)
				$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		facs_pkg::result_t want;
		if (result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: result %h arrived with none expected", $time, response);
			end else begin
				want = expected_results.pop_front();
				check_field("has_command", 16'(want.has_command),
					16'(response.has_command));
				check_field("command_high", 16'(want.command_high),
					16'(response.command_high));
				check_field("command_low", 16'(want.command_low),
					16'(response.command_low));
				check_field("result_status", 16'(want.result_status),
					16'(response.result_status));
				check_field("current_position", want.current_position,
					response.current_position);
				check_field("is_open", 16'(want.is_open), 16'(response.is_open));
				check_field("ramp_active", 16'(want.ramp_active),
					16'(response.ramp_active));
				check_field("last_of_run", 16'(want.last_of_run),
					16'(response.last_of_run));
			end
		end
	end

	initial begin
		int hold;
		@(posedge clk);
		forever begin
			hold = pick_wait(RECEIVER);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				result_stall <= 1'b0;
			end
			@(posedge clk);
			while (!result_valid) @(posedge clk);
		end
	end

	function automatic facs_pkg::item_t make_item(input logic [1:0] kind,
			input logic [9:0] target, input logic [15:0] readback);
		facs_pkg::item_t it;
		it.kind = kind;
		it.target_position = target;
		it.readback_position = readback;
		return it;
	endfunction

	task automatic send_request(input facs_pkg::item_t req);
		int gap;
		gap = pick_wait(SENDER);
		if (gap > 0) begin
			if (valid_held) begin
				item_valid <= 1'b0;
				valid_held = 1'b0;
			end
			repeat (gap) @(posedge clk);
		end
		request <= req;
		item_valid <= 1'b1;
		valid_held = 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		predict_commands(req);
		sent_count++;
	endtask

	task automatic wait_drained();
		if (valid_held) begin
			item_valid <= 1'b0;
			valid_held = 1'b0;
		end
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limits(input logic [9:0] lowest, input logic [9:0] highest);
		cfg_we <= 1'b1;
		cfg_index <= facs_pkg::CFG_INFINITY;
		cfg_wdata <= lowest;
		@(posedge clk);
		cfg_index <= facs_pkg::CFG_MACRO;
		cfg_wdata <= highest;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		inf_lim = lowest;
		mac_lim = highest;
	endtask

	task automatic test_before_open();
		send_request(make_item(facs_pkg::KIND_TICK, 10'd0, 16'h0000));
		send_request(make_item(facs_pkg::KIND_MOVE, 10'd0, 16'h0000));
		send_request(make_item(facs_pkg::KIND_MOVE, 10'h3FF, 16'hFFFF));
	endtask

	task automatic test_open_sequences();
		send_request(make_item(facs_pkg::KIND_OPEN, 10'h2AA, 16'h5555));
		send_request(make_item(facs_pkg::KIND_MOVE, 10'd200, 16'h0123));
		send_request(make_item(facs_pkg::KIND_MOVE, 10'd200, 16'h0000));
		send_request(make_item(facs_pkg::KIND_MOVE, 10'd513, 16'h0000));
		send_request(make_item(facs_pkg::KIND_MOVE, 10'd0, 16'h0000));
	endtask

	task automatic test_zero_target_init();
		send_request(make_item(facs_pkg::KIND_OPEN, 10'd0, 16'h0000));
		send_request(make_item(facs_pkg::KIND_MOVE, 10'd0, 16'hFFFF));
		send_request(make_item(facs_pkg::KIND_RELEASE, 10'd0, 16'h0000));
		send_request(make_item(facs_pkg::KIND_TICK, 10'd0, 16'h0000));
	endtask

	task automatic test_limits();
		wait_drained();
		set_limits(10'd100, 10'd900);
		send_request(make_item(facs_pkg::KIND_MOVE, 10'd99, 16'h0000));
		send_request(make_item(facs_pkg::KIND_MOVE, 10'd901, 16'h0000));
		send_request(make_item(facs_pkg::KIND_MOVE, 10'd100, 16'h0000));
	endtask

	task automatic test_release_ramp();
		wait_drained();
		set_limits(10'd0, 10'h3FF);
		send_request(make_item(facs_pkg::KIND_MOVE, 10'd340, 16'h0000));
		send_request(make_item(facs_pkg::KIND_RELEASE, 10'd0, 16'h0000));
		send_request(make_item(facs_pkg::KIND_TICK, 10'd0, 16'h0000));
		send_request(make_item(facs_pkg::KIND_TICK, 10'd0, 16'h0000));
		send_request(make_item(facs_pkg::KIND_MOVE, 10'd295, 16'h0000));
		send_request(make_item(facs_pkg::KIND_RELEASE, 10'd0, 16'h0000));
		send_request(make_item(facs_pkg::KIND_TICK, 10'd0, 16'h0000));
		send_request(make_item(facs_pkg::KIND_OPEN, 10'd0, 16'h0000));
		send_request(make_item(facs_pkg::KIND_TICK, 10'd0, 16'h0000));
		send_request(make_item(facs_pkg::KIND_MOVE, 10'd8, 16'h0008));
		send_request(make_item(facs_pkg::KIND_RELEASE, 10'd0, 16'h0000));
		send_request(make_item(facs_pkg::KIND_TICK, 10'd0, 16'h0000));
		send_request(make_item(facs_pkg::KIND_TICK, 10'd0, 16'h0000));
	endtask

	function automatic logic [9:0] pick_target();
		case ($urandom_range(0, 9))
			0: return 10'd0;
			1: return 10'h3FF;
			2: return lens_q[9:0];
			3: return 10'($urandom_range(0, 1023));
			default: return 10'($urandom_range(mac_lim, inf_lim));
		endcase
	endfunction

	function automatic logic [15:0] pick_readback();
		case ($urandom_range(0, 4))
			0: return 16'h0000;
			1: return 16'($urandom_range(0, 65535));
			2: return 16'hFFFF;
			default: return 16'($urandom_range(mac_lim, inf_lim));
		endcase
	endfunction

	task automatic run_session();
		int ticks;
		int lowcap;
		if ($urandom_range(0, 3) != 0)
			send_request(make_item(facs_pkg::KIND_OPEN, pick_target(), pick_readback()));
		repeat ($urandom_range(1, 4))
			send_request(make_item(facs_pkg::KIND_MOVE, pick_target(), pick_readback()));
		if ($urandom_range(0, 4) != 0) begin
			if ($urandom_range(0, 3) != 0) begin
				lowcap = inf_lim + 60;
				if (lowcap > mac_lim)
					lowcap = mac_lim;
				send_request(make_item(facs_pkg::KIND_MOVE,
					10'($urandom_range(lowcap, inf_lim)), pick_readback()));
			end
			send_request(make_item(facs_pkg::KIND_RELEASE, pick_target(), pick_readback()));
			ticks = 0;
			while (ramp_q && ticks < 16) begin
				case ($urandom_range(0, 11))
					0: send_request(make_item(facs_pkg::KIND_MOVE, pick_target(),
						pick_readback()));
					1: send_request(make_item(facs_pkg::KIND_RELEASE, pick_target(),
						pick_readback()));
					default: send_request(make_item(facs_pkg::KIND_TICK, pick_target(),
						pick_readback()));
				endcase
				ticks++;
			end
		end
		if ($urandom_range(0, 5) == 0)
			send_request(make_item(2'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)),
				16'($urandom_range(0, 65535))));
	endtask

	task automatic test_random();
		int phase_end;
		for (int p = 0; p < 6; p++) begin
			wait_drained();
			case (p)
				0: set_limits(10'd0, 10'h3FF);
				1: set_limits(10'h3FF, 10'h3FF);
				2: set_limits(10'd0, 10'd0);
				3: set_limits(10'd700, 10'd200);
				4: set_limits(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
				default: set_limits(10'($urandom_range(0, 300)),
					10'($urandom_range(700, 1023)));
			endcase
			phase_end = sent_count + 12;
			while (sent_count < phase_end)
				run_session();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = facs_pkg::CFG_INFINITY;
		cfg_wdata = 10'd0;
		item_valid = 1'b0;
		request = '0;
		result_stall = 1'b0;
		lens_q = 16'd0;
		motion_q = facs_pkg::MODE_DISABLED;
		prog_q = facs_pkg::MODE_DISABLED;
		open_q = facs_pkg::OPEN_CLOSED;
		ramp_q = 1'b0;
		inf_lim = 10'd0;
		mac_lim = 10'h3FF;
		calm_left[SENDER] = 0;
		calm_left[RECEIVER] = 0;
		valid_held = 1'b0;
		sent_count = 0;
		failures = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_before_open();
		test_open_sequences();
		test_zero_target_init();
		test_limits();
		test_release_ramp();
		test_random();

		wait_drained();
		repeat (20) @(posedge clk);
		if (expected_results.size() != 0)
			failures++;
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
